/* rtl/core/infix_expression_evaluator_assert.svh */
// ----------------------------------------------------------------------------
// Infix expression evaluator assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`ifndef SYNTH
`define IEE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IEE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IEE_ASSERT(lbl, prop, msg)
`define IEE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/core/iee_pkg.sv */
// ----------------------------------------------------------------------------
// Infix expression evaluator package
// Shared payload types, token format, codes and state encoding.
// ----------------------------------------------------------------------------
package iee_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } char_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
  } result_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DIVZERO   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_LPAREN = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    TK_DIGIT  = 3'd0,
    TK_LPAREN = 3'd1,
    TK_RPAREN = 3'd2,
    TK_OPER   = 3'd3,
    TK_OTHER  = 3'd4
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } token_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_TOKEN,
    BS_DISPATCH,
    BS_FINAL,
    BS_OPFILL,
    BS_APPLY,
    BS_MUL,
    BS_MULFIN,
    BS_DIV,
    BS_SAT,
    BS_ARES,
    BS_OPNDFILL,
    BS_EMIT
  } back_state_t;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam logic [63:0] QMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] QMIN = 64'h8000_0000_0000_0000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  function automatic logic [1:0] prec(input op_t op);
    logic [1:0] p;
    p = 2'd0;
    if (op == OP_ADD || op == OP_SUB) p = 2'd1;
    if (op == OP_MUL || op == OP_DIV) p = 2'd2;
    return p;
  endfunction

endpackage

/* rtl/core/iee_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iee_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/iee_front.sv */
// ----------------------------------------------------------------------------
// Expression front end
// Accepts characters and turns them into tokens for the token queue.
// ----------------------------------------------------------------------------
module iee_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            char_valid,
  output logic            char_stall,
  input  iee_pkg::char_t  char_data,
  output logic            push,
  output iee_pkg::token_t push_data,
  input  logic            full
);

  logic            tok_valid;
  iee_pkg::token_t tok;
  iee_pkg::token_t tok_next;

  always_comb begin
    tok_next.digit = 4'(char_data.ch - iee_pkg::CH_ZERO);
    tok_next.last  = char_data.is_last;
    tok_next.op    = iee_pkg::OP_LPAREN;
    tok_next.kind  = iee_pkg::TK_OTHER;
    if (char_data.ch >= iee_pkg::CH_ZERO && char_data.ch <= iee_pkg::CH_NINE) begin
      tok_next.kind = iee_pkg::TK_DIGIT;
    end else if (char_data.ch == iee_pkg::CH_LPAREN) begin
      tok_next.kind = iee_pkg::TK_LPAREN;
    end else if (char_data.ch == iee_pkg::CH_RPAREN) begin
      tok_next.kind = iee_pkg::TK_RPAREN;
    end else if (char_data.ch == iee_pkg::CH_PLUS) begin
      tok_next.kind = iee_pkg::TK_OPER;
      tok_next.op   = iee_pkg::OP_ADD;
    end else if (char_data.ch == iee_pkg::CH_MINUS) begin
      tok_next.kind = iee_pkg::TK_OPER;
      tok_next.op   = iee_pkg::OP_SUB;
    end else if (char_data.ch == iee_pkg::CH_STAR) begin
      tok_next.kind = iee_pkg::TK_OPER;
      tok_next.op   = iee_pkg::OP_MUL;
    end else if (char_data.ch == iee_pkg::CH_SLASH) begin
      tok_next.kind = iee_pkg::TK_OPER;
      tok_next.op   = iee_pkg::OP_DIV;
    end
  end

  assign char_stall = tok_valid && full;
  assign push       = tok_valid && !full;
  assign push_data  = tok;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (char_valid && !char_stall) begin
      tok_valid <= 1'b1;
      tok       <= tok_next;
    end else if (push) begin
      tok_valid <= 1'b0;
    end
  end

endmodule

/* rtl/core/iee_queue.sv */
// ----------------------------------------------------------------------------
// Token queue
// Short FIFO between front end and evaluation engine.
// ----------------------------------------------------------------------------
`include "infix_expression_evaluator_assert.svh"

module iee_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  iee_pkg::token_t push_data,
  output logic            full,
  input  logic            pop,
  output iee_pkg::token_t pop_data,
  output logic            empty
);

  localparam int CNT_W = iee_pkg::QUEUE_AW + 1;

  iee_pkg::token_t             slots [iee_pkg::QUEUE_DEPTH];
  logic [iee_pkg::QUEUE_AW-1:0] wptr;
  logic [iee_pkg::QUEUE_AW-1:0] rptr;
  logic [CNT_W-1:0]             count;

  assign full     = count == CNT_W'(iee_pkg::QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wptr] <= push_data;
        wptr        <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `IEE_ASSERT(a_queue_bound, count <= CNT_W'(iee_pkg::QUEUE_DEPTH), "token queue overfilled")

endmodule

/* rtl/core/iee_back.sv */
// ----------------------------------------------------------------------------
// Evaluation engine
// Operator and operand stacks, shunting-yard control, Q-format arithmetic.
// ----------------------------------------------------------------------------
`include "infix_expression_evaluator_assert.svh"

module iee_back #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tok_empty,
  input  iee_pkg::token_t  tok_data,
  output logic             tok_pop,
  output logic             result_valid,
  input  logic             result_stall,
  output iee_pkg::result_t result_data
);

  localparam int AW    = $clog2(STACK_DEPTH);
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int ACC_W = 63 - FRAC_BITS;
  localparam logic [ACC_W-1:0] LIMIT = '1;

  iee_pkg::back_state_t state, state_next, ret, ret_next;
  iee_pkg::token_t      tok;
  iee_pkg::status_t     err, flag_code;
  logic                 flag_en;

  logic [CW-1:0]  opnd_cnt, op_cnt;
  logic [63:0]    top0, top1;
  iee_pkg::op_t   optop, cur_op;
  logic           apply_pend, apply_next;
  logic [ACC_W-1:0] acc;
  logic           in_number;

  logic           opnd_we, op_we;
  logic [AW-1:0]  opnd_waddr, opnd_raddr, op_waddr, op_raddr;
  logic [63:0]    opnd_wdata, opnd_rdata;
  logic [2:0]     op_wdata, op_rdata;

  logic [63:0]    xm, ym, pp, res, rem, lo, q, satm;
  logic [127:0]   prod;
  logic [1:0]     pp_sh;
  logic [2:0]     mstep;
  logic [5:0]     dstep;
  logic           neg_r, satovf;
  logic           load_out;

  // Combinational helpers
  logic [ACC_W+3:0] acc_sum;
  logic             acc_ovf;
  logic [63:0]      num_q;
  logic             opnd_full, op_full, rparen_pop, oper_pop;
  iee_pkg::back_state_t after;
  logic [63:0]      xa, yb, add_r, sub_r, dz_r, sat_r;
  logic [63:0]      add_s, sub_s;
  logic             add_ovf, sub_ovf, div_big, sat_ovf_now;
  logic [31:0]      xs, ys;
  logic [6:0]       mul_sh;
  logic [63:0]      rem_sh, rem_new, q_new;
  logic             div_ge;
  iee_pkg::status_t out_status;

  assign acc_sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (ACC_W+4)'(tok.digit);
  assign acc_ovf = acc_sum > {4'b0, LIMIT};
  assign num_q   = {1'b0, acc, {FRAC_BITS{1'b0}}};

  assign opnd_full  = opnd_cnt == CW'(STACK_DEPTH);
  assign op_full    = op_cnt == CW'(STACK_DEPTH);
  assign rparen_pop = (op_cnt != '0) && (optop != iee_pkg::OP_LPAREN);
  assign oper_pop   = rparen_pop && (iee_pkg::prec(optop) >= iee_pkg::prec(tok.op));
  assign after      = tok.last ? iee_pkg::BS_FINAL : iee_pkg::BS_IDLE;

  // a = second from top, b = top
  assign xa      = top1[63] ? (64'd0 - top1) : top1;
  assign yb      = top0[63] ? (64'd0 - top0) : top0;
  assign add_s   = top1 + top0;
  assign sub_s   = top1 - top0;
  assign add_ovf = (top1[63] == top0[63]) && (add_s[63] != top1[63]);
  assign sub_ovf = (top1[63] != top0[63]) && (sub_s[63] != top1[63]);
  assign add_r   = add_ovf ? (top1[63] ? iee_pkg::QMIN : iee_pkg::QMAX) : add_s;
  assign sub_r   = sub_ovf ? (top1[63] ? iee_pkg::QMIN : iee_pkg::QMAX) : sub_s;
  assign dz_r    = (top1 == '0) ? 64'd0 : (top1[63] ? iee_pkg::QMIN : iee_pkg::QMAX);
  assign div_big = (xa >> (64 - FRAC_BITS)) >= yb;

  assign xs     = mstep[0] ? xm[63:32] : xm[31:0];
  assign ys     = mstep[1] ? ym[63:32] : ym[31:0];
  // 32 times the number of high halves in the partial product
  assign mul_sh = {pp_sh[0] & pp_sh[1], pp_sh[0] ^ pp_sh[1], 5'b0};

  assign rem_sh  = {rem[62:0], lo[63]};
  assign div_ge  = rem[63] || (rem_sh >= ym);
  assign rem_new = div_ge ? (rem_sh - ym) : rem_sh;
  assign q_new   = {q[62:0], div_ge};

  assign sat_ovf_now = neg_r ? (satovf || satm > iee_pkg::QMIN) : (satovf || satm[63]);
  assign sat_r       = neg_r ? (sat_ovf_now ? iee_pkg::QMIN : 64'd0 - satm)
                             : (sat_ovf_now ? iee_pkg::QMAX : satm);

  assign out_status = (err == iee_pkg::ST_OK && opnd_cnt != CW'(1)) ? iee_pkg::ST_MALFORMED
                                                                    : err;

  iee_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_opnd_ram (
    .clk   (clk),
    .we    (opnd_we),
    .waddr (opnd_waddr),
    .wdata (opnd_wdata),
    .raddr (opnd_raddr),
    .rdata (opnd_rdata)
  );

  iee_ram #(.WIDTH(3), .DEPTH(STACK_DEPTH)) u_op_ram (
    .clk   (clk),
    .we    (op_we),
    .waddr (op_waddr),
    .wdata (op_wdata),
    .raddr (op_raddr),
    .rdata (op_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iee_pkg::BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic [CW-1:0] opnd_m2, opnd_m3, op_m2;
    opnd_m2    = opnd_cnt - CW'(2);
    opnd_m3    = opnd_cnt - CW'(3);
    op_m2      = op_cnt - CW'(2);
    state_next = state;
    ret_next   = ret;
    apply_next = apply_pend;
    flag_en    = 1'b0;
    flag_code  = iee_pkg::ST_OK;
    tok_pop    = 1'b0;
    load_out   = 1'b0;
    opnd_we    = 1'b0;
    opnd_waddr = opnd_cnt[AW-1:0];
    opnd_wdata = num_q;
    opnd_raddr = opnd_m3[AW-1:0];
    op_we      = 1'b0;
    op_waddr   = op_cnt[AW-1:0];
    op_wdata   = tok.op;
    op_raddr   = op_m2[AW-1:0];
    unique case (state)
      iee_pkg::BS_IDLE: begin
        if (!tok_empty) begin
          tok_pop    = 1'b1;
          state_next = iee_pkg::BS_TOKEN;
        end
      end
      iee_pkg::BS_TOKEN: begin
        if (tok.kind == iee_pkg::TK_DIGIT) begin
          if (acc_ovf) begin
            flag_en   = 1'b1;
            flag_code = iee_pkg::ST_OVERFLOW;
          end
          state_next = after;
        end else begin
          if (in_number) begin
            if (opnd_full) begin
              flag_en   = 1'b1;
              flag_code = iee_pkg::ST_OVERFLOW;
            end else begin
              opnd_we = 1'b1;
            end
          end
          state_next = iee_pkg::BS_DISPATCH;
        end
      end
      iee_pkg::BS_DISPATCH: begin
        state_next = after;
        unique case (tok.kind)
          iee_pkg::TK_LPAREN: begin
            op_wdata = iee_pkg::OP_LPAREN;
            if (op_full) begin
              flag_en   = 1'b1;
              flag_code = iee_pkg::ST_OVERFLOW;
            end else begin
              op_we = 1'b1;
            end
          end
          iee_pkg::TK_RPAREN: begin
            if (rparen_pop) begin
              state_next = iee_pkg::BS_OPFILL;
              ret_next   = iee_pkg::BS_DISPATCH;
              apply_next = 1'b1;
            end else if (op_cnt == '0) begin
              flag_en   = 1'b1;
              flag_code = iee_pkg::ST_MALFORMED;
            end else begin
              // matching '(' is dropped
              state_next = iee_pkg::BS_OPFILL;
              ret_next   = after;
              apply_next = 1'b0;
            end
          end
          iee_pkg::TK_OPER: begin
            if (oper_pop) begin
              state_next = iee_pkg::BS_OPFILL;
              ret_next   = iee_pkg::BS_DISPATCH;
              apply_next = 1'b1;
            end else if (op_full) begin
              flag_en   = 1'b1;
              flag_code = iee_pkg::ST_OVERFLOW;
            end else begin
              op_we = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      iee_pkg::BS_FINAL: begin
        if (in_number) begin
          if (opnd_full) begin
            flag_en   = 1'b1;
            flag_code = iee_pkg::ST_OVERFLOW;
          end else begin
            opnd_we = 1'b1;
          end
        end else if (op_cnt != '0) begin
          state_next = iee_pkg::BS_OPFILL;
          ret_next   = iee_pkg::BS_FINAL;
          apply_next = optop != iee_pkg::OP_LPAREN;
          if (optop == iee_pkg::OP_LPAREN) begin
            flag_en   = 1'b1;
            flag_code = iee_pkg::ST_MALFORMED;
          end
        end else begin
          state_next = iee_pkg::BS_EMIT;
        end
      end
      iee_pkg::BS_OPFILL: begin
        state_next = apply_pend ? iee_pkg::BS_APPLY : ret;
      end
      iee_pkg::BS_APPLY: begin
        if (opnd_cnt < CW'(2)) begin
          flag_en    = 1'b1;
          flag_code  = iee_pkg::ST_MALFORMED;
          state_next = ret;
        end else begin
          unique case (cur_op)
            iee_pkg::OP_ADD: begin
              flag_en    = add_ovf;
              flag_code  = iee_pkg::ST_OVERFLOW;
              state_next = iee_pkg::BS_ARES;
            end
            iee_pkg::OP_SUB: begin
              flag_en    = sub_ovf;
              flag_code  = iee_pkg::ST_OVERFLOW;
              state_next = iee_pkg::BS_ARES;
            end
            iee_pkg::OP_MUL: begin
              state_next = iee_pkg::BS_MUL;
            end
            iee_pkg::OP_DIV, iee_pkg::OP_LPAREN: begin
              if (top0 == '0) begin
                flag_en    = 1'b1;
                flag_code  = iee_pkg::ST_DIVZERO;
                state_next = iee_pkg::BS_ARES;
              end else if (div_big) begin
                state_next = iee_pkg::BS_SAT;
              end else begin
                state_next = iee_pkg::BS_DIV;
              end
            end
            default: begin
              state_next = iee_pkg::BS_ARES;
            end
          endcase
        end
      end
      iee_pkg::BS_MUL: begin
        if (mstep == 3'd4) state_next = iee_pkg::BS_MULFIN;
      end
      iee_pkg::BS_MULFIN: begin
        state_next = iee_pkg::BS_SAT;
      end
      iee_pkg::BS_DIV: begin
        if (dstep == 6'd63) state_next = iee_pkg::BS_SAT;
      end
      iee_pkg::BS_SAT: begin
        flag_en    = sat_ovf_now;
        flag_code  = iee_pkg::ST_OVERFLOW;
        state_next = iee_pkg::BS_ARES;
      end
      iee_pkg::BS_ARES: begin
        opnd_we    = 1'b1;
        opnd_waddr = opnd_m2[AW-1:0];
        opnd_wdata = res;
        state_next = iee_pkg::BS_OPNDFILL;
      end
      iee_pkg::BS_OPNDFILL: begin
        state_next = ret;
      end
      iee_pkg::BS_EMIT: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = iee_pkg::BS_IDLE;
        end
      end
      default: begin
        state_next = iee_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opnd_cnt     <= '0;
      op_cnt       <= '0;
      acc          <= '0;
      in_number    <= 1'b0;
      err          <= iee_pkg::ST_OK;
      result_valid <= 1'b0;
      ret          <= iee_pkg::BS_IDLE;
      apply_pend   <= 1'b0;
    end else begin
      ret        <= ret_next;
      apply_pend <= apply_next;
      if (flag_en && err == iee_pkg::ST_OK) err <= flag_code;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (tok_pop) tok <= tok_data;
      if (opnd_we && state != iee_pkg::BS_ARES) begin
        top1     <= top0;
        top0     <= num_q;
        opnd_cnt <= opnd_cnt + 1'b1;
      end
      if (op_we) begin
        optop  <= iee_pkg::op_t'(op_wdata);
        op_cnt <= op_cnt + 1'b1;
      end
      if (state_next == iee_pkg::BS_OPFILL && state != iee_pkg::BS_OPFILL) begin
        cur_op <= optop;
        op_cnt <= op_cnt - 1'b1;
      end
      unique case (state)
        iee_pkg::BS_TOKEN: begin
          if (tok.kind == iee_pkg::TK_DIGIT) begin
            acc       <= acc_ovf ? LIMIT : acc_sum[ACC_W-1:0];
            in_number <= 1'b1;
          end else begin
            acc       <= '0;
            in_number <= 1'b0;
          end
        end
        iee_pkg::BS_FINAL: begin
          acc       <= '0;
          in_number <= 1'b0;
        end
        iee_pkg::BS_OPFILL: begin
          optop <= iee_pkg::op_t'(op_rdata);
        end
        iee_pkg::BS_APPLY: begin
          neg_r  <= top1[63] ^ top0[63];
          xm     <= xa;
          ym     <= yb;
          prod   <= '0;
          mstep  <= '0;
          rem    <= xa >> (64 - FRAC_BITS);
          lo     <= xa << FRAC_BITS;
          q      <= '0;
          dstep  <= '0;
          satovf <= 1'b1;
          satm   <= '0;
          unique case (cur_op)
            iee_pkg::OP_ADD: res <= add_r;
            iee_pkg::OP_SUB: res <= sub_r;
            default:         res <= dz_r;
          endcase
        end
        iee_pkg::BS_MUL: begin
          // one 32x32 partial product per cycle, registered in pp and then accumulated into prod
          pp    <= {32'b0, xs} * {32'b0, ys};
          pp_sh <= mstep[1:0];
          if (mstep != 3'd0) prod <= prod + ({64'b0, pp} << mul_sh);
          mstep <= mstep + 1'b1;
        end
        iee_pkg::BS_MULFIN: begin
          satm   <= prod[63+FRAC_BITS:FRAC_BITS];
          satovf <= |prod[127:64+FRAC_BITS];
        end
        iee_pkg::BS_DIV: begin
          rem    <= rem_new;
          q      <= q_new;
          lo     <= lo << 1;
          dstep  <= dstep + 1'b1;
          satm   <= q_new;
          satovf <= 1'b0;
        end
        iee_pkg::BS_SAT: begin
          res <= sat_r;
        end
        iee_pkg::BS_ARES: begin
          top0     <= res;
          opnd_cnt <= opnd_cnt - 1'b1;
        end
        iee_pkg::BS_OPNDFILL: begin
          top1 <= opnd_rdata;
        end
        iee_pkg::BS_EMIT: begin
          if (load_out) begin
            result_data.status <= out_status;
            result_data.value  <= (out_status != iee_pkg::ST_MALFORMED && opnd_cnt != '0)
                                  ? top0 : 64'd0;
            opnd_cnt  <= '0;
            op_cnt    <= '0;
            acc       <= '0;
            in_number <= 1'b0;
            err       <= iee_pkg::ST_OK;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `IEE_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == iee_pkg::BS_IDLE), "not idle after reset")
  `IEE_ASSERT(a_opnd_bound, opnd_cnt <= CW'(STACK_DEPTH), "operand count past depth")
  `IEE_ASSERT(a_ares_two, (state == iee_pkg::BS_ARES) |-> (opnd_cnt >= CW'(2)), "apply underflow")
  `IEE_ASSERT(a_emit_clear, load_out |=> (opnd_cnt == '0 && op_cnt == '0 && !in_number), "state not cleared after result")

endmodule

/* rtl/core/infix_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// Infix expression evaluator
// Character-serial shunting-yard evaluator giving a saturated Q-format value.
// ----------------------------------------------------------------------------
// Engine: a digit passes through IDLE and TOKEN, any other character also through
// DISPATCH plus its operators; the front end keeps taking one character per cycle
// until the 4-deep queue fills. Each applied operator passes OPFILL, APPLY, ARES
// and OPNDFILL (stack RAM reads); * also passes MUL, MULFIN (four 32x32 partial
// products) and SAT, / normally DIV (one quotient bit per cycle) and SAT.
// Reset: synchronous; clears counts and flags, stack RAM contents are left as is.
module infix_expression_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_valid,
  output logic             char_stall,
  input  iee_pkg::char_t   char_data,
  output logic             result_valid,
  input  logic             result_stall,
  output iee_pkg::result_t result_data
);

  logic            q_push, q_full, q_pop, q_empty;
  iee_pkg::token_t q_in, q_out;

  iee_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full)
  );

  iee_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  iee_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .tok_empty    (q_empty),
    .tok_data     (q_out),
    .tok_pop      (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix expression evaluator testbench
// Streams character sequences into the evaluator through a queue-fed driver,
// predicts each result in a local shunting-yard evaluator and checks every
// result transfer field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH   = 64;
  localparam int FRAC    = 32;
  localparam int WD_LIMIT = 20000;

  logic             clk;
  logic             rst;
  logic             char_valid;
  logic             char_stall;
  iee_pkg::char_t   char_data;
  logic             result_valid;
  logic             result_stall;
  iee_pkg::result_t result_data;

  infix_expression_evaluator #(.STACK_DEPTH(DEPTH), .FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .char_valid(char_valid), .char_stall(char_stall), .char_data(char_data),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_data(result_data)
  );

  // evaluator state
  iee_pkg::op_t     ops[DEPTH];
  int               op_cnt;
  logic [63:0]      vals[DEPTH];
  int               val_cnt;
  logic [63:0]      acc;
  bit               in_num;
  iee_pkg::status_t err;

  iee_pkg::char_t   pending_chars[$];
  iee_pkg::result_t expected_results[$];
  int      errors;
  int      results_seen;
  int      chars_sent;
  int      wd_cnt;
  bit      hold_off;
  int      tx_gap;
  int      rx_gap;

  function automatic void flag(iee_pkg::status_t s);
    if (err == iee_pkg::ST_OK) err = s;
  endfunction

  function automatic void clear_eval();
    op_cnt = 0;
    val_cnt = 0;
    acc = '0;
    in_num = 0;
    err = iee_pkg::ST_OK;
  endfunction

  function automatic logic [63:0] sat_signed(bit n, logic [63:0] m);
    if (n) begin
      if (m > iee_pkg::QMIN) begin
        flag(iee_pkg::ST_OVERFLOW);
        return iee_pkg::QMIN;
      end
      return -m;
    end
    if (m > iee_pkg::QMAX) begin
      flag(iee_pkg::ST_OVERFLOW);
      return iee_pkg::QMAX;
    end
    return m;
  endfunction

  function automatic logic [63:0] magn(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = magn(a) * magn(b);
    if ((p >> (64 + FRAC)) != 0) return sat_signed(a[63] ^ b[63], iee_pkg::QMAX + 2);
    return sat_signed(a[63] ^ b[63], p[FRAC +: 64]);
  endfunction

  function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
    logic [127:0] num;
    logic [63:0]  d;
    if (b == 0) begin
      flag(iee_pkg::ST_DIVZERO);
      if (a == 0) return '0;
      return a[63] ? iee_pkg::QMIN : iee_pkg::QMAX;
    end
    d = magn(b);
    num = {64'd0, magn(a)} << FRAC;
    if (num[127:64] >= d) return sat_signed(a[63] ^ b[63], iee_pkg::QMAX + 2);
    return sat_signed(a[63] ^ b[63], 64'(num / d));
  endfunction

  function automatic void push_val(logic [63:0] v);
    if (val_cnt >= DEPTH) begin
      flag(iee_pkg::ST_OVERFLOW);
      return;
    end
    vals[val_cnt] = v;
    val_cnt++;
  endfunction

  function automatic void push_op(iee_pkg::op_t o);
    if (op_cnt >= DEPTH) begin
      flag(iee_pkg::ST_OVERFLOW);
      return;
    end
    ops[op_cnt] = o;
    op_cnt++;
  endfunction

  function automatic void apply_op(iee_pkg::op_t o);
    logic [63:0] a, b, r;
    if (val_cnt < 2) begin
      flag(iee_pkg::ST_MALFORMED);
      return;
    end
    b = vals[val_cnt - 1];
    a = vals[val_cnt - 2];
    val_cnt -= 2;
    case (o)
      iee_pkg::OP_ADD: begin
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
          flag(iee_pkg::ST_OVERFLOW);
          r = a[63] ? iee_pkg::QMIN : iee_pkg::QMAX;
        end
      end
      iee_pkg::OP_SUB: begin
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) begin
          flag(iee_pkg::ST_OVERFLOW);
          r = a[63] ? iee_pkg::QMIN : iee_pkg::QMAX;
        end
      end
      iee_pkg::OP_MUL: r = fx_mul(a, b);
      default: r = fx_div(a, b);
    endcase
    push_val(r);
  endfunction

  function automatic void close_number();
    if (in_num) begin
      push_val(acc << FRAC);
      acc = '0;
      in_num = 0;
    end
  endfunction

  function automatic int rank(iee_pkg::op_t o);
    if (o == iee_pkg::OP_ADD || o == iee_pkg::OP_SUB) return 1;
    if (o == iee_pkg::OP_MUL || o == iee_pkg::OP_DIV) return 2;
    return 0;
  endfunction

  // Feeds one character; pushes an expected result on the last one.
  function automatic void evaluate_char(iee_pkg::char_t c);
    logic [63:0]      lim;
    logic [63:0]      dg;
    iee_pkg::op_t     o;
    iee_pkg::result_t res;
    if (c.ch >= iee_pkg::CH_ZERO && c.ch <= iee_pkg::CH_NINE) begin
      lim = (64'd1 << (63 - FRAC)) - 1;
      dg = 64'(c.ch - iee_pkg::CH_ZERO);
      if (acc > (lim - dg) / 10) begin
        flag(iee_pkg::ST_OVERFLOW);
        acc = lim;
      end else begin
        acc = acc * 10 + dg;
      end
      in_num = 1;
    end else begin
      close_number();
      if (c.ch == iee_pkg::CH_LPAREN) begin
        push_op(iee_pkg::OP_LPAREN);
      end else if (c.ch == iee_pkg::CH_RPAREN) begin
        while (op_cnt > 0 && ops[op_cnt - 1] != iee_pkg::OP_LPAREN) begin
          op_cnt--;
          apply_op(ops[op_cnt]);
        end
        if (op_cnt == 0) flag(iee_pkg::ST_MALFORMED);
        else op_cnt--;
      end else if (c.ch == iee_pkg::CH_PLUS || c.ch == iee_pkg::CH_MINUS ||
                   c.ch == iee_pkg::CH_STAR || c.ch == iee_pkg::CH_SLASH) begin
        o = (c.ch == iee_pkg::CH_PLUS) ? iee_pkg::OP_ADD :
            (c.ch == iee_pkg::CH_MINUS) ? iee_pkg::OP_SUB :
            (c.ch == iee_pkg::CH_STAR) ? iee_pkg::OP_MUL : iee_pkg::OP_DIV;
        while (op_cnt > 0 && ops[op_cnt - 1] != iee_pkg::OP_LPAREN &&
               rank(ops[op_cnt - 1]) >= rank(o)) begin
          op_cnt--;
          apply_op(ops[op_cnt]);
        end
        push_op(o);
      end
    end
    if (!c.is_last) return;
    close_number();
    while (op_cnt > 0) begin
      op_cnt--;
      if (ops[op_cnt] == iee_pkg::OP_LPAREN) flag(iee_pkg::ST_MALFORMED);
      else apply_op(ops[op_cnt]);
    end
    res.status = err;
    if (err == iee_pkg::ST_OK && val_cnt != 1) res.status = iee_pkg::ST_MALFORMED;
    res.value = '0;
    if (res.status != iee_pkg::ST_MALFORMED && val_cnt > 0) res.value = vals[val_cnt - 1];
    expected_results.push_back(res);
    clear_eval();
  endfunction

  task automatic add_text(string s);
    iee_pkg::char_t c;
    for (int i = 0; i < s.len(); i++) begin
      c.ch = s[i];
      c.is_last = (i == s.len() - 1);
      pending_chars.push_back(c);
    end
  endtask

  function automatic string rand_num();
    string s;
    int n;
    s = "";
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
    for (int i = 0; i < n; i++) s = {s, string'(byte'(8'h30 + $urandom_range(0, 9)))};
    return s;
  endfunction

  function automatic string rand_op();
    case ($urandom_range(0, 3))
      0: return "+";
      1: return "-";
      2: return "*";
      default: return "/";
    endcase
  endfunction

  // well-formed expression with random nesting
  function automatic string rand_expr(int lvl);
    string s;
    int n;
    n = $urandom_range(1, 4);
    s = "";
    for (int i = 0; i < n; i++) begin
      if (i > 0) s = {s, rand_op()};
      if (lvl > 0 && $urandom_range(0, 3) == 0) s = {s, "(", rand_expr(lvl - 1), ")"};
      else s = {s, rand_num()};
      if ($urandom_range(0, 9) == 0) s = {s, " "};
    end
    return s;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] exp);
    errors++;
    $display("mismatch %0s: got %h expected %h at %0t", what, got, exp, $realtime);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 0;
      char_data <= '0;
      tx_gap <= 0;
    end else if (!(char_valid && char_stall)) begin
      if (char_valid) begin
        chars_sent <= chars_sent + 1;
        evaluate_char(char_data);
      end
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        char_valid <= 0;
      end else if (pending_chars.size() > 0 && !hold_off) begin
        char_data <= pending_chars.pop_front();
        char_valid <= 1;
        tx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end else begin
        char_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    iee_pkg::result_t e;
    if (rst) begin
      result_stall <= 0;
      rx_gap <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report("unexpected result", result_data.value, 0);
        end else begin
          e = expected_results.pop_front();
          if (result_data.value !== e.value) report("value", result_data.value, e.value);
          if (result_data.status !== e.status)
            report("status", 64'(result_data.status), 64'(e.status));
        end
      end
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        result_stall <= 1;
      end else begin
        result_stall <= 0;
        if (result_valid && !result_stall)
          rx_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      wd_cnt <= 0;
    end else begin
      wd_cnt <= wd_cnt + 1;
      if (wd_cnt >= WD_LIMIT) begin
        $display("watchdog expired");
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    string s;
    errors = 0;
    results_seen = 0;
    chars_sent = 0;
    hold_off = 0;
    clear_eval();
    rst = 1;
    char_valid = 0;
    char_data = '0;
    result_stall = 0;
    // directed cases
    add_text("7");
    add_text("1+2*3");
    add_text("(1+2)*3");
    add_text("8-3-2");
    add_text("100/7/2");
    add_text("5/0");
    add_text("0/0");
    add_text("0-5/0");
    add_text("99999999999");
    add_text("2147483647*2147483647");
    add_text("0-2147483647-2147483647");
    add_text("1/3");
    add_text("1+");
    add_text("(1+2");
    add_text("1+2)");
    add_text("()");
    add_text(" 4 ,* x3\tz");
    add_text("12 34");
    add_text("5/0+99999999999");
    add_text({{70{"("}}, "1", {70{")"}}});
    add_text({{65{"1+"}}, "1"});
    add_text("*");
    add_text("\xff\x00");
    add_text("9");
    repeat (4) @(posedge clk);
    rst <= 0;
    wait (pending_chars.size() == 0);
    // hold the sender until the directed results have drained
    hold_off = 1;
    wait (expected_results.size() == 0 && !char_valid);
    repeat (20) @(posedge clk);
    hold_off = 0;
    while (chars_sent < 1150) begin
      case ($urandom_range(0, 9))
        0: begin
          s = "";
          repeat ($urandom_range(1, 8)) s = {s, string'(byte'($urandom_range(0, 255)))};
          add_text(s);
        end
        1: begin
          s = rand_expr(2);
          s = s.substr(0, $urandom_range(0, s.len() - 1));
          add_text({s, "+"});
        end
        default: add_text(rand_expr(3));
      endcase
      wait (pending_chars.size() == 0);
    end
    wait (expected_results.size() == 0 && !char_valid);
    repeat (200) @(posedge clk);
    $display("sent %0d characters, checked %0d results", chars_sent, results_seen);
    $display("covered precedence, nesting, saturation, divide by zero and bad input");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/iee_pkg.sv
rtl/core/iee_ram.sv
rtl/core/iee_front.sv
rtl/core/iee_queue.sv
rtl/core/iee_back.sv
rtl/core/infix_expression_evaluator.sv
verif/testbench.sv
